/* rtl/hwpg_pkg.sv */
// Shared constants, types and helper functions of the hue wheel pixel generator.
package hwpg_pkg;

    // Field and register widths.
    localparam int COORD_BITS = 12;
    localparam int HUE_BITS   = 16;
    localparam int SIZE_W     = 13;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [SIZE_W-1:0]    SIZE_RESET       = 13'd256;

    // Doubled coordinates and the CORDIC datapath.
    localparam int DX_W         = ((SIZE_W > COORD_BITS + 1) ? SIZE_W : COORD_BITS + 1) + 1;
    localparam int PRE_SCALE    = 16;
    localparam int X_W          = DX_W + PRE_SCALE + 3;
    localparam int CORDIC_STEPS = 28;
    localparam int ANGLE_W      = 32;

    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    // Angle plus three quarters of a turn plus half a hue LSB for rounding.
    localparam logic [ANGLE_W-1:0] HUE_OFFSET =
        32'hC000_0000 + (ANGLE_W'(1) << (ANGLE_W - 1 - HUE_BITS));
    localparam logic [HUE_BITS-1:0] CENTER_HUE = HUE_BITS'(3) << (HUE_BITS - 2);

    // atan(2^-i) in turns scaled by 2^32.
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    // Color sectors of the hue circle.
    localparam int SECT_W = 3;
    localparam logic [SECT_W-1:0] SEC_RY = 3'd0;
    localparam logic [SECT_W-1:0] SEC_YG = 3'd1;
    localparam logic [SECT_W-1:0] SEC_GC = 3'd2;
    localparam logic [SECT_W-1:0] SEC_CB = 3'd3;
    localparam logic [SECT_W-1:0] SEC_BM = 3'd4;
    localparam logic [SECT_W-1:0] SEC_MR = 3'd5;

    localparam logic [CH_W-1:0] CH_FULL    = 8'hFF;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h00;
    localparam logic [CH_W-1:0] ALPHA_FULL = 8'hFF;

    // Vector travelling through the CORDIC stages.
    typedef struct packed {
        logic                      valid;
        logic                      center;
        logic signed [X_W-1:0]     x;
        logic signed [X_W-1:0]     y;
        logic        [ANGLE_W-1:0] z;
    } t_cvec;

    // Angle handed to the color stages.
    typedef struct packed {
        logic                 valid;
        logic                 center;
        logic [ANGLE_W-1:0]   z;
    } t_angle;

    // Finished pixel color.
    typedef struct packed {
        logic            valid;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    // floor(255 * v / 2^HUE_BITS) for v up to 2^HUE_BITS.
    function automatic logic [CH_W-1:0] ramp(input logic [HUE_BITS:0] v);
        logic [HUE_BITS+CH_W:0] p;
        p = (HUE_BITS+CH_W+1)'({v, {CH_W{1'b0}}}) - (HUE_BITS+CH_W+1)'(v);
        return p[HUE_BITS+CH_W-1:HUE_BITS];
    endfunction

endpackage

/* rtl/hue_wheel_pixel_generator.sv */
// Top level of the hue wheel pixel generator: config registers, pipeline and output buffer.
// The 28-stage CORDIC plus four more stages run in lockstep ahead of the output register.
// Throughput: one pixel per cycle while the skid entry is empty and the pipeline advances.
// A one-entry skid buffer behind the output register takes one more pixel while o_valid
// waits; once it is full the pipeline halts and o_stall holds requests off until it drains.
// Reset is synchronous, active low: all valid bits clear and both sizes return to 256.
// No clearing pass is needed; requests are taken in the first cycle after reset.
module hue_wheel_pixel_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hwpg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hwpg_pkg::SIZE_W-1:0]       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [hwpg_pkg::COORD_BITS-1:0]   i_pixel_x,
    input  logic [hwpg_pkg::COORD_BITS-1:0]   i_pixel_y,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [hwpg_pkg::CH_W-1:0]         o_red,
    output logic [hwpg_pkg::CH_W-1:0]         o_green,
    output logic [hwpg_pkg::CH_W-1:0]         o_blue,
    output logic [hwpg_pkg::CH_W-1:0]         o_alpha
);
    import hwpg_pkg::*;

    logic [SIZE_W-1:0] r_frame_width;
    logic [SIZE_W-1:0] r_frame_height;

    logic   s_en;
    logic   s_take;
    logic   s_fire;
    t_cvec  s_vec;
    t_angle s_angle;
    t_pixel s_tail;

    t_pixel r_out;
    t_pixel r_skid;
    t_pixel n_out;
    t_pixel n_skid;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= SIZE_RESET;
            r_frame_height <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together unless the skid entry is occupied.
    assign s_en    = !r_skid.valid;
    assign o_stall = r_skid.valid;

    hwpg_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (s_en),
        .i_valid        (i_valid),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_vec          (s_vec)
    );

    hwpg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_vec   (s_vec),
        .o_angle (s_angle)
    );

    hwpg_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_angle (s_angle),
        .o_pixel (s_tail)
    );

    // Output register with one skid entry behind it.
    assign s_take = s_en && s_tail.valid;
    assign s_fire = r_out.valid && !i_stall;

    always_comb begin
        n_out  = r_out;
        n_skid = r_skid;
        if (!r_out.valid || s_fire) begin
            if (r_skid.valid) begin
                n_out        = r_skid;
                n_skid.valid = 1'b0;
            end else if (s_take) begin
                n_out = s_tail;
            end else begin
                n_out.valid = 1'b0;
            end
        end else if (s_take) begin
            n_skid = s_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else begin
            r_out  <= n_out;
            r_skid <= n_skid;
        end
    end

    assign o_valid = r_out.valid;
    assign o_red   = r_out.red;
    assign o_green = r_out.green;
    assign o_blue  = r_out.blue;
    assign o_alpha = ALPHA_FULL;

    // The skid entry only fills behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid.valid |-> r_out.valid)
        else $error("skid entry held without an output request");

    // A full skid entry drains in the cycle the output is taken.
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid.valid && !i_stall) |=> !r_skid.valid)
        else $error("skid entry did not drain");

    // A finished pixel arriving at a stalled output lands in the skid entry.
    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out.valid && i_stall && !r_skid.valid && s_tail.valid) |=> r_skid.valid)
        else $error("pixel lost at stalled output");

endmodule

/* rtl/hwpg_prep.sv */
// Input stage: doubled coordinates, half-turn pre-rotation and center detection.
module hwpg_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [hwpg_pkg::COORD_BITS-1:0] i_pixel_x,
    input  logic [hwpg_pkg::COORD_BITS-1:0] i_pixel_y,
    input  logic [hwpg_pkg::SIZE_W-1:0]   i_frame_width,
    input  logic [hwpg_pkg::SIZE_W-1:0]   i_frame_height,
    output hwpg_pkg::t_cvec               o_vec
);
    import hwpg_pkg::*;

    logic signed [DX_W-1:0] n_dx;
    logic signed [DX_W-1:0] n_dy;
    logic signed [X_W-1:0]  n_x0;
    logic signed [X_W-1:0]  n_y0;
    t_cvec                  n_vec;
    t_cvec                  r_vec;

    // Doubled offsets from the frame center, scaled up for the CORDIC.
    always_comb begin
        n_dx = DX_W'(i_frame_width)  - DX_W'({i_pixel_x, 1'b0});
        n_dy = DX_W'(i_frame_height) - DX_W'({i_pixel_y, 1'b0});
        n_x0 = X_W'(n_dx) <<< PRE_SCALE;
        n_y0 = X_W'(n_dy) <<< PRE_SCALE;

        n_vec.valid  = i_valid;
        n_vec.center = (n_dx == '0) && (n_dy == '0);
        // Vectors in the left half plane are turned by half a turn first.
        if (n_dx[DX_W-1]) begin
            n_vec.x = -n_x0;
            n_vec.y = -n_y0;
            n_vec.z = HALF_TURN;
        end else begin
            n_vec.x = n_x0;
            n_vec.y = n_y0;
            n_vec.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec.valid <= 1'b0;
        end else if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

/* rtl/hwpg_cordic.sv */
// Vectoring CORDIC: one register stage per rotation step.
module hwpg_cordic (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  hwpg_pkg::t_cvec  i_vec,
    output hwpg_pkg::t_angle o_angle
);
    import hwpg_pkg::*;

    t_cvec s_stage [CORDIC_STEPS+1];

    assign s_stage[0] = i_vec;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        t_cvec                 n_stage;
        t_cvec                 r_stage;
        logic signed [X_W-1:0] n_xs;
        logic signed [X_W-1:0] n_ys;

        // Rotate toward the x axis; the shifts round toward minus infinity.
        always_comb begin
            n_xs          = s_stage[i].x >>> i;
            n_ys          = s_stage[i].y >>> i;
            n_stage.valid  = s_stage[i].valid;
            n_stage.center = s_stage[i].center;
            if (!s_stage[i].y[X_W-1]) begin
                n_stage.x = s_stage[i].x + n_ys;
                n_stage.y = s_stage[i].y - n_xs;
                n_stage.z = s_stage[i].z + ATAN_TURNS[i];
            end else begin
                n_stage.x = s_stage[i].x - n_ys;
                n_stage.y = s_stage[i].y + n_xs;
                n_stage.z = s_stage[i].z - ATAN_TURNS[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stage.valid <= 1'b0;
            end else if (i_en) begin
                r_stage <= n_stage;
            end
        end

        assign s_stage[i+1] = r_stage;
    end

    assign o_angle.valid  = s_stage[CORDIC_STEPS].valid;
    assign o_angle.center = s_stage[CORDIC_STEPS].center;
    assign o_angle.z      = s_stage[CORDIC_STEPS].z;

endmodule

/* rtl/hwpg_color.sv */
// Hue rounding and HSV to RGB conversion in three register stages.
module hwpg_color (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  hwpg_pkg::t_angle i_angle,
    output hwpg_pkg::t_pixel o_pixel
);
    import hwpg_pkg::*;

    logic [ANGLE_W-1:0]  n_zr;
    logic [HUE_BITS-1:0] n_hue;
    logic                r_hue_valid;
    logic [HUE_BITS-1:0] r_hue;

    logic [HUE_BITS+2:0] n_h6;
    logic                r_sec_valid;
    logic [SECT_W-1:0]   r_sector;
    logic [HUE_BITS-1:0] r_frac;

    logic [HUE_BITS:0]   n_q;
    logic [CH_W-1:0]     n_rf;
    logic [CH_W-1:0]     n_rq;
    t_pixel              n_pix;
    t_pixel              r_pix;

    // Stage 1: shift the angle by three quarters of a turn and round to hue bits; a center pixel takes CENTER_HUE.
    always_comb begin
        n_zr  = i_angle.z + HUE_OFFSET;
        n_hue = i_angle.center ? CENTER_HUE : n_zr[ANGLE_W-1 -: HUE_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_valid <= 1'b0;
        end else if (i_en) begin
            r_hue_valid <= i_angle.valid;
            r_hue       <= n_hue;
        end
    end

    // Stage 2: six times the hue splits into sector and ramp fraction.
    assign n_h6 = (HUE_BITS+3)'({r_hue, 2'b00}) + (HUE_BITS+3)'({r_hue, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_valid <= 1'b0;
        end else if (i_en) begin
            r_sec_valid <= r_hue_valid;
            r_sector    <= n_h6[HUE_BITS+2:HUE_BITS];
            r_frac      <= n_h6[HUE_BITS-1:0];
        end
    end

    // Stage 3: rising and falling ramps, then the channel pattern of the sector.
    always_comb begin
        n_q  = (HUE_BITS+1)'(1) << HUE_BITS;
        n_q  = n_q - (HUE_BITS+1)'(r_frac);
        n_rf = ramp((HUE_BITS+1)'(r_frac));
        n_rq = ramp(n_q);
        n_pix.valid = r_sec_valid;
        case (r_sector)
            SEC_RY: begin
                n_pix.red = CH_FULL; n_pix.green = n_rf;    n_pix.blue = CH_ZERO;
            end
            SEC_YG: begin
                n_pix.red = n_rq;    n_pix.green = CH_FULL; n_pix.blue = CH_ZERO;
            end
            SEC_GC: begin
                n_pix.red = CH_ZERO; n_pix.green = CH_FULL; n_pix.blue = n_rf;
            end
            SEC_CB: begin
                n_pix.red = CH_ZERO; n_pix.green = n_rq;    n_pix.blue = CH_FULL;
            end
            SEC_BM: begin
                n_pix.red = n_rf;    n_pix.green = CH_ZERO; n_pix.blue = CH_FULL;
            end
            default: begin
                n_pix.red = CH_FULL; n_pix.green = CH_ZERO; n_pix.blue = n_rq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix.valid <= 1'b0;
        end else if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_pixel = r_pix;

    // A hue below one turn never yields a sector past magenta-red.
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_valid |-> (r_sector <= SEC_MR))
        else $error("sector out of range");

endmodule
